// File: src/acmg_pkg.sv
// Shared constants and codes for the antialiased corner mask generator.
package acmg_pkg;

  localparam int MAX_RADIUS_DEF = 64;
  localparam int FRAC_BITS      = 16;

  localparam logic [7:0] FULL_COVER = 8'hff;

  localparam logic CMD_GEN  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_RADIUS = 2'd1;
  localparam logic [1:0] ST_RANGE  = 2'd2;

endpackage

// File: src/acmg_sqrt.sv
// Digit-serial square root of radicand << 2*FRAC_BITS, one root bit per cycle.
module acmg_sqrt
  import acmg_pkg::*;
#(
  parameter int RW = 7
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [2*RW-1:0]           radicand,
  output logic                      done,
  output logic [RW+FRAC_BITS-1:0]   root
);

  localparam int SW    = 2 * RW;
  localparam int RB    = RW + FRAC_BITS;
  localparam int REM_W = RB + 2;
  localparam int CW    = $clog2(RB + 1);

  logic [SW-1:0]     sh;
  logic [REM_W-1:0]  rem;
  logic [CW-1:0]     cnt;
  logic              run;

  logic [REM_W+1:0]  cur;
  logic [REM_W+1:0]  trial;
  logic [REM_W+1:0]  diff;
  logic              ge;

  // Bring down the next pair of radicand bits; zeros follow the top word.
  always_comb begin
    cur   = {rem, sh[SW-1 -: 2]};
    trial = (REM_W + 2)'({root, 2'b01});
    ge    = (cur >= trial);
    diff  = cur - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && (cnt == CW'(RB - 1))) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh   <= radicand;
      rem  <= '0;
      root <= '0;
      cnt  <= '0;
    end else if (run) begin
      sh   <= sh << 2;
      rem  <= ge ? REM_W'(diff) : REM_W'(cur);
      root <= {root[RB-2:0], ge};
      cnt  <= cnt + CW'(1);
    end
  end

endmodule

// File: src/antialiased_corner_mask_generator.sv
// Top level of the antialiased quarter-circle corner mask generator.
//
// Command channel: a word (command, row, col) is taken on a clock edge with
// start high and busy low. Each command returns one result word on coverage
// and status, marked by a one-cycle done strobe; the receiver cannot stall.
// Config: radius_we writes radius_data into the radius register; the user
// must write it only while idle, as the block itself does not enforce it.
// Read: result appears the cycle after the command (one registered read of
// the coverage store); reads may issue back to back, one per cycle.
// Generate: clear the whole 2**(2*IW)-byte store (4096 at MAX_RADIUS 64),
// then for each i in 1..R load the root unit, run the bit-serial root
// (RW+16 root bits, 23 at the default, one root bit per cycle) and wait
// for it to finish, register the coverage byte, make two read-modify-write
// passes (a read state and a write state each), then fw fill writes and
// one step, then raise done with status ok.
// A zero radius answers the next cycle with status 1 and leaves the store
// alone.
// Reset: run the same clearing pass; busy stays high for its length.
module antialiased_corner_mask_generator
  import acmg_pkg::*;
#(
  parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       command,
  input  logic [5:0] row,
  input  logic [5:0] col,
  input  logic       radius_we,
  input  logic [6:0] radius_data,
  output logic       done,
  output logic [7:0] coverage,
  output logic [1:0] status
);

  localparam int RW = $clog2(MAX_RADIUS + 1);
  localparam int IW = (MAX_RADIUS > 1) ? $clog2(MAX_RADIUS) : 1;
  localparam int AW = 2 * IW;
  localparam int SW = 2 * RW;
  localparam int RB = RW + FRAC_BITS;
  localparam int CW = ((RW > 7) ? RW : 7) + 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLEAR = 4'd1;
  localparam logic [3:0] S_LOAD  = 4'd2;
  localparam logic [3:0] S_SQRT  = 4'd3;
  localparam logic [3:0] S_TAIL  = 4'd4;
  localparam logic [3:0] S_RDA   = 4'd5;
  localparam logic [3:0] S_WRA   = 4'd6;
  localparam logic [3:0] S_RDB   = 4'd7;
  localparam logic [3:0] S_WRB   = 4'd8;
  localparam logic [3:0] S_FILL  = 4'd9;
  localparam logic [3:0] S_NEXT  = 4'd10;

  logic [3:0]    state;
  logic [6:0]    radius;
  logic [RW-1:0] rr;
  logic [RW-1:0] idx;
  logic [SW-1:0] sq;
  logic [7:0]    t;
  logic [IW-1:0] ri;
  logic [IW-1:0] ca;
  logic [IW-1:0] fc;
  logic [RW-1:0] nleft;
  logic [AW-1:0] clr_addr;
  logic          clr_gen;
  logic          rd_hit;

  logic [7:0]    mem [0:(1 << AW) - 1];
  logic [7:0]    rdata;
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic [AW-1:0] raddr;

  logic [RW-1:0] eff;
  logic          out_range;
  logic          accept;

  logic          sq_done;
  logic [RB-1:0] root;

  logic [15:0]   fr;
  logic [24:0]   tsum;
  logic [RW-1:0] fw;

  assign busy     = (state != S_IDLE);
  assign accept   = start && (state == S_IDLE);
  assign coverage = rd_hit ? rdata : 8'd0;

  // Clamp the radius to the store size and flag a row or col at or past it.
  always_comb begin
    eff       = ({2'b00, radius} > 9'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(radius);
    out_range = (CW'(row) >= CW'(eff)) || (CW'(col) >= CW'(eff));
  end

  // Coverage byte from the root fraction, round half up, capped at full.
  always_comb begin
    fr   = root[FRAC_BITS-1:0];
    tsum = 25'({fr, 8'd0}) - 25'(fr) + 25'(32768);
    fw   = root[RB-1:FRAC_BITS];
    if (fw >= rr) begin
      fw = rr - RW'(1);
    end
  end

  acmg_sqrt #(
    .RW (RW)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_LOAD),
    .radicand (sq),
    .done     (sq_done),
    .root     (root)
  );

  // Store port select: clear sweep, max-write, edge fill, or command read.
  always_comb begin
    we    = 1'b0;
    waddr = clr_addr;
    wdata = 8'd0;
    raddr = {IW'(row), IW'(col)};
    case (state)
      S_CLEAR: begin
        we = 1'b1;
      end
      S_RDA: begin
        raddr = {ri, ca};
      end
      S_WRA: begin
        we    = (t > rdata);
        waddr = {ri, ca};
        wdata = t;
      end
      S_RDB: begin
        raddr = {ca, ri};
      end
      S_WRB: begin
        we    = (t > rdata);
        waddr = {ca, ri};
        wdata = t;
      end
      S_FILL: begin
        we    = 1'b1;
        waddr = {ri, fc};
        wdata = FULL_COVER;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // Control: sequencer, strobe and radius register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      clr_gen  <= 1'b0;
      radius   <= 7'd0;
      done     <= 1'b0;
      rd_hit   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (radius_we) begin
        radius <= radius_data;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (command == CMD_READ) begin
              done   <= 1'b1;
              rd_hit <= !out_range;
            end else if (eff == '0) begin
              done   <= 1'b1;
              rd_hit <= 1'b0;
            end else begin
              clr_addr <= '0;
              clr_gen  <= 1'b1;
              state    <= S_CLEAR;
            end
          end
        end
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == {AW{1'b1}}) begin
            state <= clr_gen ? S_LOAD : S_IDLE;
          end
        end
        S_LOAD: begin
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (sq_done) begin
            state <= S_TAIL;
          end
        end
        S_TAIL: begin
          state <= S_RDA;
        end
        S_RDA: begin
          state <= S_WRA;
        end
        S_WRA: begin
          state <= S_RDB;
        end
        S_RDB: begin
          state <= S_WRB;
        end
        S_WRB: begin
          state <= (nleft != '0) ? S_FILL : S_NEXT;
        end
        S_FILL: begin
          if (nleft == RW'(1)) begin
            state <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (idx == rr) begin
            done   <= 1'b1;
            rd_hit <= 1'b0;
            state  <= S_IDLE;
          end else begin
            state <= S_LOAD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers; no reset needed.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (command == CMD_READ) begin
            status <= out_range ? ST_RANGE : ST_OK;
          end else if (eff == '0) begin
            status <= ST_RADIUS;
          end else begin
            rr  <= eff;
            idx <= RW'(1);
            sq  <= SW'(eff) * SW'(eff) - SW'(1);
          end
        end
      end
      S_TAIL: begin
        t     <= (tsum[24:16] > 9'd255) ? FULL_COVER : tsum[23:16];
        ri    <= IW'(rr - idx);
        ca    <= IW'(rr - fw - RW'(1));
        fc    <= IW'(rr - RW'(1));
        nleft <= fw;
      end
      S_FILL: begin
        fc    <= fc - IW'(1);
        nleft <= nleft - RW'(1);
      end
      S_NEXT: begin
        if (idx == rr) begin
          status <= ST_OK;
        end else begin
          // Step to the next row: (i+1)^2 = i^2 + 2i + 1.
          idx <= idx + RW'(1);
          sq  <= sq - SW'({idx, 1'b1});
        end
      end
      default: begin
        status <= status;
      end
    endcase
  end

endmodule

// File: verif/antialiased_corner_mask_generator_tb.sv
// Self-checking testbench for the antialiased corner mask generator.
`timescale 1ns / 100ps

module antialiased_corner_mask_generator_tb
  import acmg_pkg::*;
();

  localparam int MASK_CELLS = MAX_RADIUS_DEF * MAX_RADIUS_DEF;
  localparam int WORD_COUNT = 950;

  typedef struct packed {
    logic [7:0] coverage;
    logic [1:0] status;
  } cover_word_t;

  // Shadow copy of the coverage store and radius; predicts one result word
  // per accepted command word and checks the DUT's words in order.
  class corner_mask_scoreboard;
    logic [7:0]  mask_mem [MASK_CELLS];
    logic [6:0]  radius_reg;
    cover_word_t expected_words [$];
    int          errors;

    function new();
      foreach (mask_mem[k]) mask_mem[k] = '0;
      radius_reg = '0;
      errors = 0;
    endfunction

    function void set_radius(logic [6:0] value);
      radius_reg = value;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    // Integer square root of a 64-bit value, bit by bit.
    function logic [63:0] root_fixed(logic [63:0] value);
      logic [63:0] root;
      logic [63:0] probe;
      root = '0;
      probe = 64'd1 << 62;
      while (probe > value) probe = probe >> 2;
      while (probe != 0) begin
        if (value >= root + probe) begin
          value = value - (root + probe);
          root = (root >> 1) + probe;
        end else begin
          root = root >> 1;
        end
        probe = probe >> 2;
      end
      return root;
    endfunction

    function void raise_cell(int r, int c, logic [7:0] value);
      if (r >= MAX_RADIUS_DEF || c >= MAX_RADIUS_DEF) return;
      if (value > mask_mem[r * MAX_RADIUS_DEF + c]) mask_mem[r * MAX_RADIUS_DEF + c] = value;
    endfunction

    // Clear the store, then draw the quarter circle edge by edge.
    function void draw_corner(int rr);
      logic [63:0] span;
      logic [63:0] edge_w;
      int          whole;
      int          frac_part;
      int          shade;
      foreach (mask_mem[k]) mask_mem[k] = '0;
      for (int i = 1; i <= rr; i++) begin
        span = 64'(rr) * 64'(rr) - 64'(i) * 64'(i);
        edge_w = root_fixed(span << 32);
        whole = int'(edge_w >> FRAC_BITS);
        frac_part = int'(edge_w[15:0]);
        shade = (frac_part * 255 + 32768) >> 16;
        if (shade > 255) shade = 255;
        if (whole >= rr) whole = rr - 1;
        raise_cell(rr - i, rr - whole - 1, 8'(shade));
        raise_cell(rr - whole - 1, rr - i, 8'(shade));
        for (int n = 1; n <= whole; n++) raise_cell(rr - i, rr - n, FULL_COVER);
      end
    endfunction

    function void note_word(logic cmd, logic [5:0] r, logic [5:0] c);
      cover_word_t exp_word;
      int          rr;
      rr = (radius_reg > MAX_RADIUS_DEF) ? MAX_RADIUS_DEF : int'(radius_reg);
      exp_word.coverage = '0;
      exp_word.status = ST_OK;
      if (cmd == CMD_GEN) begin
        if (rr < 1) exp_word.status = ST_RADIUS;
        else draw_corner(rr);
      end else if (int'(r) >= rr || int'(c) >= rr) begin
        exp_word.status = ST_RANGE;
      end else begin
        exp_word.coverage = mask_mem[int'(r) * MAX_RADIUS_DEF + int'(c)];
      end
      expected_words.push_back(exp_word);
    endfunction

    function void check_result(logic [7:0] cov, logic [1:0] st);
      cover_word_t exp_word;
      if (expected_words.size() == 0) begin
        errors++;
        $display("%0t: result word with none expected, coverage %0d status %0d",
                 $time, cov, st);
        return;
      end
      exp_word = expected_words.pop_front();
      if (cov !== exp_word.coverage) begin
        errors++;
        $display("%0t: coverage mismatch, expected %0d actual %0d",
                 $time, exp_word.coverage, cov);
      end
      if (st !== exp_word.status) begin
        errors++;
        $display("%0t: status mismatch, expected %0d actual %0d",
                 $time, exp_word.status, st);
      end
    endfunction

    function void flag_leftovers();
      if (expected_words.size() != 0) begin
        errors++;
        $display("%0t: %0d result words never arrived, expected coverage %0d status %0d",
                 $time, expected_words.size(), expected_words[0].coverage,
                 expected_words[0].status);
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  logic       command = CMD_READ;
  logic [5:0] row = '0;
  logic [5:0] col = '0;
  logic       radius_we = 1'b0;
  logic [6:0] radius_data = '0;
  logic       done;
  logic [7:0] coverage;
  logic [1:0] status;

  corner_mask_scoreboard sb = new();
  int words_sent = 0;

  antialiased_corner_mask_generator dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .command     (command),
    .row         (row),
    .col         (col),
    .radius_we   (radius_we),
    .radius_data (radius_data),
    .done        (done),
    .coverage    (coverage),
    .status      (status)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watch both sides of the block at every edge. Note the accepted word
  // before checking the strobe so that a same-cycle answer still finds its
  // expectation; the queue keeps the order either way.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_word(command, row, col);
      if (done) sb.check_result(coverage, status);
    end
  end

  // Drop start, then hold until no word is outstanding and the block is idle.
  task automatic drain_block();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0 || busy) @(posedge clk);
  endtask

  // Write the radius only while nothing is in flight.
  task automatic write_radius(logic [6:0] value);
    drain_block();
    radius_we <= 1'b1;
    radius_data <= value;
    @(posedge clk);
    radius_we <= 1'b0;
    sb.set_radius(value);
  endtask

  // Present one command word after a random gap; advance once it is taken.
  task automatic send_word(logic cmd, logic [5:0] r, logic [5:0] c, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    command <= cmd;
    row <= r;
    col <= c;
    do @(posedge clk); while (busy);
    words_sent++;
  endtask

  task automatic send_generate(bit no_gap);
    send_word(CMD_GEN, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)), no_gap);
  endtask

  // Mostly small radii so generates stay cheap; now and then the largest,
  // values past the maximum that clamp, and zero.
  function automatic logic [6:0] pick_radius();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return 7'd0;
    if (pick <= 10) return 7'($urandom_range(1, 8));
    if (pick <= 15) return 7'($urandom_range(9, 40));
    if (pick <= 17) return 7'($urandom_range(41, 64));
    if (pick == 18) return 7'd64;
    return 7'($urandom_range(65, 127));
  endfunction

  // One random phase: new radius, usually a generate, then a run of reads
  // aimed mostly inside the corner, with a stray generate or a full drain
  // mixed in now and then.
  task automatic run_phase();
    logic [6:0] rad;
    int         eff;
    int         reads;
    bit         burst;
    logic [5:0] r;
    logic [5:0] c;
    rad = pick_radius();
    write_radius(rad);
    eff = (rad > MAX_RADIUS_DEF) ? MAX_RADIUS_DEF : int'(rad);
    burst = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 9) < 6) send_generate(burst);
    reads = $urandom_range(20, 60);
    for (int k = 0; k < reads && words_sent < WORD_COUNT; k++) begin
      if ($urandom_range(0, 39) == 0) drain_block();
      if ($urandom_range(0, 49) == 0) begin
        send_generate(burst);
      end else begin
        if (eff > 0 && $urandom_range(0, 3) != 0) begin
          r = 6'($urandom_range(0, eff - 1));
          c = 6'($urandom_range(0, eff - 1));
        end else begin
          r = 6'($urandom_range(0, 63));
          c = 6'($urandom_range(0, 63));
        end
        send_word(CMD_READ, r, c, burst);
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Zero radius: generate is rejected, every read is out of range.
    write_radius(7'd0);
    send_generate(1'b0);
    send_word(CMD_READ, 6'd0, 6'd0, 1'b0);

    // Smallest corner, with a read inside it and reads just past its edge.
    write_radius(7'd1);
    send_generate(1'b0);
    send_word(CMD_READ, 6'd0, 6'd0, 1'b0);
    send_word(CMD_READ, 6'd0, 6'd1, 1'b0);
    send_word(CMD_READ, 6'd1, 6'd0, 1'b0);

    // Largest corner and its far cells.
    write_radius(7'd64);
    send_generate(1'b0);
    send_word(CMD_READ, 6'd0, 6'd0, 1'b1);
    send_word(CMD_READ, 6'd63, 6'd63, 1'b1);
    send_word(CMD_READ, 6'd0, 6'd63, 1'b1);
    send_word(CMD_READ, 6'd63, 6'd0, 1'b1);
    send_word(CMD_READ, 6'd32, 6'd17, 1'b0);

    // Radius above the maximum clamps to it.
    write_radius(7'd127);
    send_generate(1'b0);
    send_word(CMD_READ, 6'd63, 6'd63, 1'b0);
    send_word(CMD_READ, 6'd0, 6'd0, 1'b0);

    // Shrink the radius without a generate: reads see the old mask.
    write_radius(7'd5);
    send_word(CMD_READ, 6'd2, 6'd3, 1'b0);
    send_word(CMD_READ, 6'd4, 6'd4, 1'b0);
    send_word(CMD_READ, 6'd5, 6'd0, 1'b0);

    // A rejected generate must leave the store alone.
    write_radius(7'd0);
    send_generate(1'b0);
    send_word(CMD_READ, 6'd63, 6'd63, 1'b0);
    write_radius(7'd100);
    send_word(CMD_READ, 6'd63, 6'd0, 1'b0);
    send_word(CMD_READ, 6'd10, 6'd60, 1'b0);

    while (words_sent < WORD_COUNT) run_phase();

    drain_block();
    repeat (8) @(posedge clk);
    sb.flag_leftovers();
    if (sb.errors == 0) begin
      $display("[antialiased_corner_mask_generator] OK");
    end else begin
      $display("[antialiased_corner_mask_generator] ERROR");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #(24_000_000);
    $display("[antialiased_corner_mask_generator] ERROR");
    $finish;
  end

endmodule

// File: filelist.f
src/acmg_pkg.sv
src/acmg_sqrt.sv
src/antialiased_corner_mask_generator.sv
verif/antialiased_corner_mask_generator_tb.sv
